FILE: design/zba_pkg.sv
package zba_pkg;

    localparam int MAP_BLOCKS_DEF = 64;
    localparam int MAP_BLOCK_BITS_LOG_DEF = 13;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_SPACE    = 2'd1;
    localparam logic [1:0] ST_OUT_RANGE   = 2'd2;
    localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

    localparam logic [1:0] REG_DATA_ZONE_START = 2'd0;
    localparam logic [1:0] REG_ZONE_COUNT      = 2'd1;
    localparam logic [1:0] REG_MAP_BLOCKS_USED = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] allocated_zone;
        logic        map_changed;
        logic [5:0]  changed_map_block;
    } result_t;

    function automatic logic [5:0] first_set64(input logic [63:0] v);
        logic [63:0] x;
        logic [5:0]  r;
        x = v;
        r = 6'd0;
        for (int k = 5; k >= 0; k--)
        begin
            if ((x & ((64'd1 << (1 << k)) - 64'd1)) == 64'd0)
            begin
                r[k] = 1'b1;
                x = x >> (1 << k);
            end
        end
        return r;
    endfunction

endpackage

FILE: design/zba_bitmap_ram.sv
module zba_bitmap_ram
    import zba_pkg::*;
#(
    parameter int WORDS = 8192,
    parameter int AW = 13
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [63:0]   rdata
);

    logic [63:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/zone_bitmap_allocator_core.sv
// First-fit zone allocator over a bitmap held in a single-port-write, registered-read
// memory of 64-bit words. After reset a clearing pass writes every word (MAP_BLOCKS *
// 2^MAP_BLOCK_BITS_LOG / 64 words, 8192 at the defaults) before the first transaction
// is taken. An allocate scans the words in use one after another (memory read, then
// find-first-clear on the registered word) up to the first one with a clear bit. A
// free runs a range check and a memory read, then the bit test with the write-back and
// the result.
module zone_bitmap_allocator_core
    import zba_pkg::*;
#(
    parameter int MAP_BLOCKS = MAP_BLOCKS_DEF,
    parameter int MAP_BLOCK_BITS_LOG = MAP_BLOCK_BITS_LOG_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // zone_number[31:0]
    input  logic [0:0]  s_axis_tuser,   // req_type[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status[1:0], allocated_zone[33:2],
                                        // map_changed[34], changed_map_block[40:35]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int TOTAL_BITS = MAP_BLOCKS << MAP_BLOCK_BITS_LOG;
    localparam int WORDS = (TOTAL_BITS + 63) / 64;
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LW = 7 + MAP_BLOCK_BITS_LOG;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ARD   = 3'd2;
    localparam logic [2:0] S_ACHK  = 3'd3;
    localparam logic [2:0] S_ASUM  = 3'd4;
    localparam logic [2:0] S_FCHK  = 3'd5;
    localparam logic [2:0] S_FRD   = 3'd6;
    localparam logic [2:0] S_FBIT  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [AW:0]   clr_reg, clr_next;
    logic [AW-1:0] w_reg, w_next;
    logic [LW-1:0] g_reg, g_next;
    logic [31:0]   zn_reg, zn_next;
    logic [31:0]   dzs_reg, zc_reg;
    logic [6:0]    mbu_reg;
    logic [63:0]   dirty_reg, dirty_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;
    logic          res_valid_reg, res_valid_next;
    result_t       res_reg, res_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;

    logic [6:0]    biu;
    logic [LW-1:0] limit, base, span, nbase;
    logic [63:0]   freebits;
    logic [5:0]    fb;
    logic [32:0]   sum, idx;
    logic [5:0]    blk;

    zba_bitmap_ram #(.WORDS(WORDS), .AW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign biu = (mbu_reg > 7'(MAP_BLOCKS)) ? 7'(MAP_BLOCKS) : mbu_reg;
    assign limit = LW'(biu) << MAP_BLOCK_BITS_LOG;
    assign base = LW'({w_reg, 6'd0});
    assign nbase = LW'({({1'b0, w_reg} + (AW+1)'(1)), 6'd0});
    assign span = limit - base;
    assign blk = 6'(g_reg >> MAP_BLOCK_BITS_LOG);
    assign sum = 33'(g_reg) + {1'b0, dzs_reg};
    assign idx = {1'b0, zn_reg} - {1'b0, dzs_reg} + 33'd1;
    assign fb = first_set64(freebits);

    always_comb
    begin
        freebits = ~rdata;
        if (span < LW'(64))
        begin
            freebits = freebits & ((64'd1 << span[5:0]) - 64'd1);
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !res_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, out_reg.changed_map_block, out_reg.map_changed,
                           out_reg.allocated_zone, out_reg.status};

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        w_next = w_reg;
        g_next = g_reg;
        zn_next = zn_reg;
        dirty_next = dirty_reg;
        res_valid_next = res_valid_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        we = 1'b0;
        waddr = w_reg;
        wdata = rdata;
        raddr = w_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid_reg && (!out_valid_reg || m_axis_tready))
        begin
            out_valid_next = 1'b1;
            out_next = res_reg;
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = (clr_reg == '0) ? 64'd1 : 64'd0;
                clr_next = clr_reg + (AW+1)'(1);
                if (clr_reg == (AW+1)'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    zn_next = s_axis_tdata;
                    w_next = '0;
                    if (s_axis_tuser[0] != REQ_ALLOC)
                    begin
                        state_next = S_FCHK;
                    end
                    else if (biu == 7'd0)
                    begin
                        res_valid_next = 1'b1;
                        res_next = '{ST_NO_SPACE, 32'd0, 1'b0, 6'd0};
                    end
                    else
                    begin
                        state_next = S_ARD;
                    end
                end
            end
            S_ARD:
            begin
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (freebits != 64'd0)
                begin
                    g_next = base + LW'(fb);
                    state_next = S_ASUM;
                end
                else if (nbase >= limit)
                begin
                    res_valid_next = 1'b1;
                    res_next = '{ST_NO_SPACE, 32'd0, 1'b0, 6'd0};
                    state_next = S_IDLE;
                end
                else
                begin
                    w_next = w_reg + AW'(1);
                    state_next = S_ARD;
                end
            end
            S_ASUM:
            begin
                res_valid_next = 1'b1;
                state_next = S_IDLE;
                if (sum == 33'd0 || (sum - 33'd1) >= {1'b0, zc_reg})
                begin
                    res_next = '{ST_NO_SPACE, 32'd0, 1'b0, 6'd0};
                end
                else
                begin
                    we = 1'b1;
                    wdata = rdata | (64'd1 << g_reg[5:0]);
                    dirty_next = dirty_reg | (64'd1 << blk);
                    res_next = '{ST_OK, 32'(sum - 33'd1), 1'b1, blk};
                end
            end
            S_FCHK:
            begin
                if (zn_reg < dzs_reg || zn_reg >= zc_reg || idx >= 33'(limit))
                begin
                    res_valid_next = 1'b1;
                    res_next = '{ST_OUT_RANGE, 32'd0, 1'b0, 6'd0};
                    state_next = S_IDLE;
                end
                else
                begin
                    g_next = LW'(idx);
                    w_next = AW'(idx >> 6);
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                state_next = S_FBIT;
            end
            S_FBIT:
            begin
                res_valid_next = 1'b1;
                state_next = S_IDLE;
                if (rdata[g_reg[5:0]] == 1'b0)
                begin
                    res_next = '{ST_ALREADY_FREE, 32'd0, 1'b0, 6'd0};
                end
                else
                begin
                    we = 1'b1;
                    wdata = rdata & ~(64'd1 << g_reg[5:0]);
                    dirty_next = dirty_reg | (64'd1 << blk);
                    res_next = '{ST_OK, 32'd0, 1'b1, blk};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            dirty_reg <= '0;
            out_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            dzs_reg <= '0;
            zc_reg <= '0;
            mbu_reg <= 7'd1;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            dirty_reg <= dirty_next;
            out_valid_reg <= out_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DATA_ZONE_START: dzs_reg <= cfg_data;
                    REG_ZONE_COUNT:      zc_reg <= cfg_data;
                    REG_MAP_BLOCKS_USED: mbu_reg <= cfg_data[6:0];
                    default:             mbu_reg <= mbu_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        g_reg <= g_next;
        zn_reg <= zn_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule

FILE: dv/zone_bitmap_allocator_core_tb.sv
module zone_bitmap_allocator_core_tb;
    import zba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORDS = (MAP_BLOCKS_DEF << MAP_BLOCK_BITS_LOG_DEF) / 64;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] zone;
        logic        changed;
        logic [5:0]  block;
    } zone_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    logic [63:0]  zone_words [WORDS];
    logic [31:0]  zone_base;
    logic [31:0]  zone_limit;
    logic [6:0]   blocks_used;
    zone_result_t pending_results [$];
    logic [31:0]  granted_zones [$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  sent_count;
    int  checked_count = 0;
    bit  stall_en;

    zone_bitmap_allocator_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic zone_result_t predict_request(input logic req, input logic [31:0] zn);
        zone_result_t r;
        int           blocks;
        int           limit;
        logic [63:0]  freebits;
        logic [32:0]  sum;
        longint       idx;
        int           g;
        r = '0;
        blocks = (blocks_used > MAP_BLOCKS_DEF) ? MAP_BLOCKS_DEF : int'(blocks_used);
        limit = blocks << MAP_BLOCK_BITS_LOG_DEF;
        if (req == REQ_ALLOC)
        begin
            r.status = ST_NO_SPACE;
            for (int w = 0; w < limit / 64; w++)
            begin
                freebits = ~zone_words[w];
                if (freebits != 64'd0)
                begin
                    g = -1;
                    for (int b = 63; b >= 0; b--)
                    begin
                        if (freebits[b])
                        begin
                            g = w * 64 + b;
                        end
                    end
                    sum = 33'(g) + {1'b0, zone_base};
                    if (sum != 33'd0 && (sum - 33'd1) < {1'b0, zone_limit})
                    begin
                        zone_words[w][g % 64] = 1'b1;
                        r.status = ST_OK;
                        r.zone = sum[31:0] - 32'd1;
                        r.changed = 1'b1;
                        r.block = 6'(g >> MAP_BLOCK_BITS_LOG_DEF);
                    end
                    break;
                end
            end
        end
        else if (zn < zone_base || zn >= zone_limit)
        begin
            r.status = ST_OUT_RANGE;
        end
        else
        begin
            idx = longint'(zn) - longint'(zone_base) + 1;
            if (idx >= limit)
            begin
                r.status = ST_OUT_RANGE;
            end
            else if (!zone_words[idx / 64][idx % 64])
            begin
                r.status = ST_ALREADY_FREE;
            end
            else
            begin
                zone_words[idx / 64][idx % 64] = 1'b0;
                r.status = ST_OK;
                r.changed = 1'b1;
                r.block = 6'(idx >> MAP_BLOCK_BITS_LOG_DEF);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("MISMATCH %s at result %0d: got %0h, expected %0h",
                 what, checked_count, got, want);
    endtask

    always @(posedge clk)
    begin
        zone_result_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[1:0] != want.status)
                    report_mismatch("status", 32'(m_axis_tdata[1:0]), 32'(want.status));
                if (m_axis_tdata[33:2] != want.zone)
                    report_mismatch("allocated_zone", m_axis_tdata[33:2], want.zone);
                if (m_axis_tdata[34] != want.changed)
                    report_mismatch("map_changed", 32'(m_axis_tdata[34]), 32'(want.changed));
                if (m_axis_tdata[40:35] != want.block)
                    report_mismatch("changed_map_block", 32'(m_axis_tdata[40:35]),
                                    32'(want.block));
            end
            checked_count++;
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_en && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 11);
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic req, input logic [31:0] zn);
        zone_result_t want;
        if (stall_en && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= zn;
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = predict_request(req, zn);
        if (req == REQ_ALLOC && want.status == ST_OK)
            granted_zones.push_back(want.zone);
        pending_results.push_back(want);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_zone_regs(input logic [31:0] base, input logic [31:0] zlimit,
                                   input logic [6:0] blocks);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_DATA_ZONE_START;
        cfg_data <= base;
        @(negedge clk);
        cfg_index <= REG_ZONE_COUNT;
        cfg_data <= zlimit;
        @(negedge clk);
        cfg_index <= REG_MAP_BLOCKS_USED;
        cfg_data <= {25'd0, blocks};
        @(negedge clk);
        cfg_we <= 1'b0;
        zone_base = base;
        zone_limit = zlimit;
        blocks_used = blocks;
        @(negedge clk);
    endtask

    task automatic free_granted;
        logic [31:0] z;
        z = (granted_zones.size() == 0) ? $urandom() :
            granted_zones[$urandom_range(0, granted_zones.size() - 1)];
        send_request(~REQ_ALLOC, z);
    endtask

    task automatic test_reset_defaults;
        send_request(REQ_ALLOC, 32'd0);
        send_request(~REQ_ALLOC, 32'd0);
        send_request(~REQ_ALLOC, 32'hFFFF_FFFF);
    endtask

    task automatic test_directed;
        write_zone_regs(32'd100, 32'd106, 7'd1);
        repeat (6) send_request(REQ_ALLOC, 32'hFFFF_FFFF);
        send_request(~REQ_ALLOC, 32'd99);
        send_request(~REQ_ALLOC, 32'd106);
        send_request(~REQ_ALLOC, 32'd102);
        send_request(~REQ_ALLOC, 32'd102);
        send_request(~REQ_ALLOC, 32'd100);
        send_request(REQ_ALLOC, 32'd0);
        write_zone_regs(32'd0, 32'hFFFF_FFFF, 7'd0);
        send_request(REQ_ALLOC, 32'd0);
        send_request(~REQ_ALLOC, 32'd1);
        write_zone_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127);
        send_request(REQ_ALLOC, 32'd0);
        send_request(~REQ_ALLOC, 32'hFFFF_FFFE);
        write_zone_regs(32'd0, 32'hFFFF_FFFF, 7'd2);
        send_request(~REQ_ALLOC, 32'd16383);
        send_request(~REQ_ALLOC, 32'd16384);
        send_request(REQ_ALLOC, 32'd0);
    endtask

    task automatic test_random_phase(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_request(REQ_ALLOC, $urandom());
            else if (pick < 80)
                free_granted();
            else if (pick < 92)
                send_request(~REQ_ALLOC, zone_base + $urandom_range(0, 300) - 3);
            else
                send_request(~REQ_ALLOC, $urandom());
        end
    endtask

    task automatic test_random;
        write_zone_regs(32'd50, 32'd400, 7'd1);
        test_random_phase(180);
        write_zone_regs(32'd1000, 32'hFFFF_FFFF, 7'd64);
        test_random_phase(200);
        write_zone_regs($urandom_range(0, 5000), $urandom_range(5000, 20000), 7'd127);
        test_random_phase(180);
        write_zone_regs(32'd0, 32'd9000, 7'd3);
        test_random_phase(180);
        stall_en = 1'b0;
        write_zone_regs(32'd7, 32'd2000, 7'd64);
        test_random_phase(190);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sent_count = 0;
        stall_en = 1'b1;
        for (int w = 0; w < WORDS; w++)
            zone_words[w] = 64'd0;
        zone_words[0][0] = 1'b1;
        zone_base = 32'd0;
        zone_limit = 32'd0;
        blocks_used = 7'd1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_directed();
        test_random();
        drain();
        $display("Sent %0d allocate/free requests under the reset settings and nine written",
                 sent_count);
        $display("register settings, %0d results checked", checked_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
